// ===== hdl/sptrv_pkg.sv =====
// Shared types, constants and helper functions for the same-price trade run volume unit.
// Used by sptrv_ctrl, sptrv_dp and same_price_trade_run_volume_unit.
// Depends on nothing else.
package sptrv_pkg;

  // Event kinds carried in the input tuser.
  localparam logic [1:0] CMD_TRADE  = 2'd0;
  localparam logic [1:0] CMD_BOOK   = 2'd1;
  localparam logic [1:0] CMD_HALT   = 2'd2;
  localparam logic [1:0] CMD_RESUME = 2'd3;

  // Field widths.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TIME_W   = 27;
  localparam int unsigned QTY_W    = 20;
  localparam int unsigned SIZE_W   = QTY_W + 1;
  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned VOL_W    = 32;
  localparam int unsigned ENTRY_W  = TIME_W + SIZE_W;

  // Input tdata layout, lowest bit first.
  localparam int unsigned NOW_LSB   = 0;
  localparam int unsigned READY_BIT = NOW_LSB + TIME_W;
  localparam int unsigned SIDE_BIT  = READY_BIT + 1;
  localparam int unsigned QTY_LSB   = SIDE_BIT + 1;
  localparam int unsigned PRICE_LSB = QTY_LSB + QTY_W;
  localparam int unsigned BID_LSB   = PRICE_LSB + PRICE_W;
  localparam int unsigned ASK_LSB   = BID_LSB + PRICE_W;
  localparam int unsigned S_TDATA_W = 152;
  localparam int unsigned M_TDATA_W = 32;

  // Window length after reset, in milliseconds.
  localparam logic [TIME_W-1:0] WINDOW_RESET = 27'd1000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture the accepted input item
    logic retire;    // retire the oldest ring entry from the sum
    logic mark_ovf;  // the retirement is due to a full ring
    logic apply;     // carry out the event and load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic goes_expire;  // the offered item needs the expiry walk
    logic expired;      // the oldest entry has reached the window age
    logic need_ovf;     // the item extends a run while the ring is full
    logic out_free;     // the result register can take a new result
  } dp_stat_t;

  // Saturate a 33-bit signed value to 32 bits.
  function automatic logic signed [VOL_W-1:0] sat32(input logic signed [VOL_W:0] v);
    logic signed [VOL_W-1:0] r;
    if (v[VOL_W] != v[VOL_W-1]) begin
      r = v[VOL_W] ? {1'b1, {(VOL_W-1){1'b0}}} : {1'b0, {(VOL_W-1){1'b1}}};
    end else begin
      r = v[VOL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/sptrv_ctrl.sv =====
// Controller state machine of the same-price trade run volume unit.
// Sequences capture, the expiry walk over the ring and the final update.
// Depends on sptrv_pkg.
module sptrv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  sptrv_pkg::dp_stat_t stat,
  output sptrv_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = stat.goes_expire ? ST_FETCH : ST_APPLY;
        end
      end
      ST_FETCH: begin
        // The ring memory read of the oldest entry completes here.
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.expired) begin
          cmd.retire = 1'b1;
          state_next = ST_FETCH;
        end else if (stat.need_ovf) begin
          cmd.retire   = 1'b1;
          cmd.mark_ovf = 1'b1;
          state_next   = ST_APPLY;
        end else begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (stat.out_free) begin
          cmd.apply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/sptrv_dp.sv =====
// Datapath of the same-price trade run volume unit: item registers, the
// timestamped ring memory, the running sum, the run state and the result register.
// Depends on sptrv_pkg.
module sptrv_dp #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [sptrv_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  input  logic [sptrv_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [sptrv_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tuser,
  input  logic                                 cfg_we,
  input  logic [sptrv_pkg::TIME_W-1:0]         cfg_wdata,
  input  sptrv_pkg::dp_cmd_t                   cmd,
  output sptrv_pkg::dp_stat_t                  stat
);

  localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int unsigned PSUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(RING_DEPTH);
  localparam logic [PSUM_W-1:0] DEPTH_SUM = PSUM_W'(RING_DEPTH);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(RING_DEPTH - 1);

  localparam int unsigned TW = sptrv_pkg::TIME_W;
  localparam int unsigned SW = sptrv_pkg::SIZE_W;
  localparam int unsigned PW = sptrv_pkg::PRICE_W;
  localparam int unsigned VW = sptrv_pkg::VOL_W;

  // Captured input item.
  logic [sptrv_pkg::CMD_W-1:0]  item_cmd;
  logic [TW-1:0]                item_now;
  logic                         item_ready;
  logic                         item_side;
  logic [sptrv_pkg::QTY_W-1:0]  item_qty;
  logic signed [PW-1:0]         item_price;
  logic signed [PW-1:0]         item_bid;
  logic signed [PW-1:0]         item_ask;

  // Ring memory and its registered read port.
  logic [sptrv_pkg::ENTRY_W-1:0] ring_mem [RING_DEPTH];
  logic [sptrv_pkg::ENTRY_W-1:0] rd_entry;

  // Control and run state.
  logic [IDX_W-1:0]     ring_head, ring_head_next;
  logic [CNT_W-1:0]     ring_count, ring_count_next;
  logic signed [VW-1:0] volume_sum, volume_sum_next;
  logic                 prev_valid, prev_valid_next;
  logic                 prev_side, prev_side_next;
  logic signed [PW-1:0] prev_price, prev_price_next;
  logic signed [PW-1:0] prev_bid, prev_bid_next;
  logic signed [PW-1:0] prev_ask, prev_ask_next;
  logic                 started, started_next;
  logic                 feed_down, feed_down_next;
  logic [TW-1:0]        window_len, window_len_next;
  logic                 ovf_flag, ovf_flag_next;
  logic                 out_valid, out_valid_next;
  logic signed [VW-1:0] out_volume, out_volume_next;
  logic                 out_ovf, out_ovf_next;

  // Derived values.
  logic signed [SW-1:0]   item_size;
  logic [TW-1:0]          rd_time;
  logic signed [SW-1:0]   rd_size;
  logic [TW:0]            age;
  logic                   same_run;
  logic signed [VW-1:0]   retire_sum;
  logic signed [VW-1:0]   add_sum;
  logic signed [PW:0]     spread;
  logic                   wide;
  logic                   quote_chg;
  logic [IDX_W-1:0]       head_inc;
  logic [PSUM_W-1:0]      push_sum;
  logic [IDX_W-1:0]       push_idx;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;

  // Signed size of the held trade: buys count positive, sells negative.
  assign item_size = item_side ? -$signed({1'b0, item_qty}) : $signed({1'b0, item_qty});

  assign rd_time = rd_entry[sptrv_pkg::ENTRY_W-1:SW];
  assign rd_size = $signed(rd_entry[SW-1:0]);

  // Age of the oldest entry; a time before the entry's own never expires it.
  assign age = {1'b0, item_now} - {1'b0, rd_time};

  assign same_run  = prev_valid && (item_side == prev_side) && (item_price == prev_price);
  assign retire_sum = sptrv_pkg::sat32({volume_sum[VW-1], volume_sum} - (VW+1)'(rd_size));
  assign add_sum    = sptrv_pkg::sat32({volume_sum[VW-1], volume_sum} + (VW+1)'(item_size));
  assign spread     = {item_ask[PW-1], item_ask} - {item_bid[PW-1], item_bid};
  assign wide       = spread > (PW+1)'(1);
  assign quote_chg  = (item_bid != prev_bid) || (item_ask != prev_ask);

  // Ring index arithmetic, modulo the depth.
  assign head_inc = (ring_head == LAST_IDX) ? '0 : ring_head + IDX_W'(1);
  assign push_sum = PSUM_W'(ring_head) + PSUM_W'(ring_count);
  assign push_idx = (push_sum >= DEPTH_SUM) ? IDX_W'(push_sum - DEPTH_SUM) : IDX_W'(push_sum);

  // Status towards the controller.
  always_comb begin
    stat.goes_expire = started && ((s_axis_tuser == sptrv_pkg::CMD_TRADE) ||
                                   (s_axis_tuser == sptrv_pkg::CMD_BOOK));
    stat.expired     = (ring_count != '0) && !age[TW] && (age[TW-1:0] >= window_len);
    stat.need_ovf    = (item_cmd == sptrv_pkg::CMD_TRADE) && same_run &&
                       (ring_count == DEPTH_CNT);
    stat.out_free    = !out_valid || m_axis_tready;
  end

  // Next-state logic for retirement and for carrying out an event.
  always_comb begin
    ring_head_next  = ring_head;
    ring_count_next = ring_count;
    volume_sum_next = volume_sum;
    prev_valid_next = prev_valid;
    prev_side_next  = prev_side;
    prev_price_next = prev_price;
    prev_bid_next   = prev_bid;
    prev_ask_next   = prev_ask;
    started_next    = started;
    feed_down_next  = feed_down;
    window_len_next = cfg_we ? cfg_wdata : window_len;
    ovf_flag_next   = ovf_flag;
    out_valid_next  = out_valid && !m_axis_tready;
    out_volume_next = out_volume;
    out_ovf_next    = out_ovf;
    wr_en           = 1'b0;
    wr_addr         = push_idx;

    if (cmd.latch) begin
      ovf_flag_next = 1'b0;
    end

    if (cmd.retire) begin
      volume_sum_next = retire_sum;
      ring_head_next  = head_inc;
      ring_count_next = ring_count - CNT_W'(1);
      if (cmd.mark_ovf) begin
        ovf_flag_next = 1'b1;
      end
    end

    if (cmd.apply) begin
      unique case (item_cmd) inside
        sptrv_pkg::CMD_RESUME: begin
          feed_down_next = 1'b0;
        end
        sptrv_pkg::CMD_HALT: begin
          feed_down_next  = 1'b1;
          volume_sum_next = '0;
          out_valid_next  = 1'b1;
          out_volume_next = '0;
          out_ovf_next    = 1'b0;
        end
        sptrv_pkg::CMD_TRADE, sptrv_pkg::CMD_BOOK: begin
          if (!started) begin
            if (item_ready) begin
              started_next = 1'b1;
            end
          end else begin
            if (item_cmd == sptrv_pkg::CMD_TRADE) begin
              wr_en = 1'b1;
              if (same_run) begin
                ring_count_next = ring_count + CNT_W'(1);
                volume_sum_next = add_sum;
              end else begin
                // A new run starts with this trade alone.
                wr_addr         = '0;
                ring_head_next  = '0;
                ring_count_next = CNT_W'(1);
                volume_sum_next = VW'(item_size);
              end
              if (wide || quote_chg) begin
                volume_sum_next = '0;
                ring_head_next  = '0;
                ring_count_next = '0;
              end
              prev_valid_next = 1'b1;
              prev_side_next  = item_side;
              prev_price_next = item_price;
            end else begin
              // A quote change on a book update empties the ring but keeps the sum; a wide spread clears both.
              if (wide) begin
                volume_sum_next = '0;
                ring_head_next  = '0;
                ring_count_next = '0;
              end else if (quote_chg) begin
                ring_head_next  = '0;
                ring_count_next = '0;
              end
            end
            if (feed_down) begin
              volume_sum_next = '0;
            end
            prev_bid_next   = item_bid;
            prev_ask_next   = item_ask;
            out_valid_next  = 1'b1;
            out_volume_next = volume_sum_next;
            out_ovf_next    = ovf_flag;
          end
        end
      endcase
    end
  end

  // Capture of the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_cmd   <= s_axis_tuser;
      item_now   <= s_axis_tdata[sptrv_pkg::NOW_LSB +: TW];
      item_ready <= s_axis_tdata[sptrv_pkg::READY_BIT];
      item_side  <= s_axis_tdata[sptrv_pkg::SIDE_BIT];
      item_qty   <= s_axis_tdata[sptrv_pkg::QTY_LSB +: sptrv_pkg::QTY_W];
      item_price <= $signed(s_axis_tdata[sptrv_pkg::PRICE_LSB +: PW]);
      item_bid   <= $signed(s_axis_tdata[sptrv_pkg::BID_LSB +: PW]);
      item_ask   <= $signed(s_axis_tdata[sptrv_pkg::ASK_LSB +: PW]);
    end
  end

  // Ring memory: one write port, one registered read of the oldest entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= {item_now, item_size};
    end
    rd_entry <= ring_mem[ring_head];
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_head  <= '0;
      ring_count <= '0;
      volume_sum <= '0;
      prev_valid <= 1'b0;
      prev_side  <= 1'b0;
      prev_price <= '0;
      prev_bid   <= '0;
      prev_ask   <= '0;
      started    <= 1'b0;
      feed_down  <= 1'b0;
      window_len <= sptrv_pkg::WINDOW_RESET;
      ovf_flag   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      ring_head  <= ring_head_next;
      ring_count <= ring_count_next;
      volume_sum <= volume_sum_next;
      prev_valid <= prev_valid_next;
      prev_side  <= prev_side_next;
      prev_price <= prev_price_next;
      prev_bid   <= prev_bid_next;
      prev_ask   <= prev_ask_next;
      started    <= started_next;
      feed_down  <= feed_down_next;
      window_len <= window_len_next;
      ovf_flag   <= ovf_flag_next;
      out_valid  <= out_valid_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_volume <= out_volume_next;
    out_ovf    <= out_ovf_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_volume;
  assign m_axis_tuser  = out_ovf;

  // The ring never holds more entries than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= DEPTH_CNT)
    else $error("ring count beyond depth");

  // Retirement only ever happens with a non-empty ring.
  a_retire_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.retire |-> (ring_count != '0))
    else $error("retirement from an empty ring");

  // While the feed is down a trade or book update reports zero.
  a_feed_down_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && feed_down && started &&
     ((item_cmd == sptrv_pkg::CMD_TRADE) || (item_cmd == sptrv_pkg::CMD_BOOK)))
    |=> (m_axis_tvalid && (m_axis_tdata == '0)))
    else $error("non-zero result while the feed is down");

endmodule

// ===== hdl/same_price_trade_run_volume_unit.sv =====
// Same-price trade run volume unit: top level joining controller and datapath.
// Depends on sptrv_pkg, sptrv_ctrl and sptrv_dp.
//
// Takes trade, book-update, feed-interrupted and feed-resumed events and reports
// the saturating signed volume of the current run of trades at one side and price,
// summed over a time window held in a ring of RING_DEPTH entries. One event is
// handled at a time. Resume, interrupt and events before the book is ready need
// no ring walk; otherwise each entry checked takes a registered read of the ring
// memory (FETCH) and a compare (CHECK), repeated while the oldest entry has aged
// out. A result waiting in the output register holds up only the final step of
// the next event. There is no clearing pass after reset. The user must write the
// window length through cfg_we/cfg_wdata while idle; the block does not enforce it.
module same_price_trade_run_volume_unit #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // Fields from bit 0: now_ms[26:0], book_ready[27], trade_side[28],
  // trade_quantity[48:29], trade_price[80:49], best_bid[112:81],
  // best_ask[144:113], zero padding[151:145].
  input  logic [sptrv_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // Fields from bit 0: command[1:0].
  input  logic [sptrv_pkg::CMD_W-1:0]     s_axis_tuser,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: run_volume[31:0].
  output logic [sptrv_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: ring_overflow[0].
  output logic                            m_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we,
  input  logic [sptrv_pkg::TIME_W-1:0]    cfg_wdata
);

  sptrv_pkg::dp_cmd_t  cmd;
  sptrv_pkg::dp_stat_t stat;

  // Sequencing of each event.
  sptrv_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // Ring, running sum and result register.
  sptrv_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule
